FILE: src/lhdp_pkg.sv
// ----------------------------------------------------------------------------
// lhdp_pkg
// Shared types and constants for the link header decapsulation parser.
// ----------------------------------------------------------------------------
package lhdp_pkg;

  // Default depth limit of an MPLS label stack
  localparam int unsigned MaxLabelsDefault = 8;

  // Configuration register indexes
  localparam logic CFG_LINK_TYPE = 1'b0;
  localparam logic CFG_IPV6_CODE = 1'b1;

  // Link types
  localparam logic [2:0] LT_NULL     = 3'd0;
  localparam logic [2:0] LT_ETHERNET = 3'd1;
  localparam logic [2:0] LT_PPP      = 3'd2;
  localparam logic [2:0] LT_FDDI     = 3'd3;
  localparam logic [2:0] LT_COOKED   = 3'd4;

  // Verdict status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NONIP_NULL = 3'd1;
  localparam logic [2:0] ST_NONIP_PPPOE = 3'd2;
  localparam logic [2:0] ST_NONIP_PPP  = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;
  localparam logic [2:0] ST_DEEP_STACK = 3'd5;

  // Protocol values
  localparam logic [15:0] ETH_MPLS  = 16'h8847;
  localparam logic [15:0] ETH_VLAN  = 16'h8100;
  localparam logic [15:0] ETH_PPPOE = 16'h8864;
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] PPP_IPV4  = 16'h0021;
  localparam logic [15:0] PPP_IPV6  = 16'h0057;
  localparam logic [15:0] PPP_MPLS  = 16'h0281;

  // Null link families that are always accepted
  localparam logic [31:0] FAM_INET   = 32'd2;
  localparam logic [31:0] FAM_INET6A = 32'd24;
  localparam logic [31:0] FAM_INET6B = 32'd28;
  localparam logic [31:0] FAM_INET6C = 32'd30;

  // Fixed link header sizes
  localparam logic [4:0] HS_NULL     = 5'd4;
  localparam logic [4:0] HS_ETHERNET = 5'd14;
  localparam logic [4:0] HS_PPP      = 5'd4;
  localparam logic [4:0] HS_FDDI     = 5'd21;
  localparam logic [4:0] HS_COOKED   = 5'd16;

  // Fixed offsets and label stack bases
  localparam logic [5:0] OFF_VLAN     = 6'd18;
  localparam logic [5:0] OFF_VLAN2    = 6'd22;
  localparam logic [5:0] OFF_PPPOE    = 6'd22;
  localparam logic [3:0] MPLS_BASE_ETH = 4'd14;
  localparam logic [3:0] MPLS_BASE_PPP = 4'd4;

  // Input item
  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } lhdp_in_t;

  // Result item
  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  payload_offset;
    logic [4:0]  header_size;
    logic [31:0] protocol_code;
    logic        had_mpls;
    logic [3:0]  label_count;
  } lhdp_out_t;

endpackage

FILE: src/link_header_decap_parser_core.sv
// ----------------------------------------------------------------------------
// link_header_decap_parser_core
// Byte-serial link header parser that gives one verdict per packet.
// ----------------------------------------------------------------------------
// Packet bytes are taken one per cycle, back to back, each one advancing a
// small parser state held in registers. The item marked as the last byte of
// a packet loads the verdict into the result register, where it is offered
// on the next cycle; the parser is cleared at that same edge so the next
// packet may start right away. Bytes that are not last are taken even while
// a verdict waits; a last byte waits only while the result register holds a
// verdict that is not being taken. Configuration is written through a plain
// write port and takes effect from the next byte.
module link_header_decap_parser_core
  import lhdp_pkg::*;
#(
  parameter int unsigned MAX_LABELS = MaxLabelsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lhdp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lhdp_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_VLAN   = 2'd1;
  localparam logic [1:0] PH_PPPOE  = 2'd2;
  localparam logic [1:0] PH_MPLS   = 2'd3;

  localparam logic [3:0] MaxLabelsW = 4'(MAX_LABELS);

  // Configuration registers
  logic [2:0]  link_type_q;
  logic [7:0]  ipv6_code_q;

  // Parser state
  logic [7:0]  pos_q, pos_d;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] proto_q, proto_d;
  logic [15:0] inner_q, inner_d;
  logic [2:0]  vstatus_q, vstatus_d;
  logic [5:0]  voffset_q, voffset_d;
  logic [4:0]  vheader_q, vheader_d;
  logic [3:0]  labels_q, labels_d;
  logic        done_q, done_d;
  logic [3:0]  mbase_q, mbase_d;
  logic        vmpls_q, vmpls_d;

  // Result register
  logic        out_valid_q;
  lhdp_out_t   out_data_q;
  lhdp_out_t   result;

  logic        in_fire;
  logic        dec;
  logic [2:0]  dec_st;
  logic [5:0]  dec_off;
  logic [4:0]  dec_hs;
  logic [7:0]  mpls_rel;
  logic [6:0]  mpls_off;
  logic [15:0] shift16;
  logic [7:0]  b;

  assign b          = in_data_i.packet_byte;
  assign in_ready_o = !out_valid_q || out_ready_i || !in_data_i.last_byte;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_type_q <= LT_ETHERNET;
      ipv6_code_q <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINK_TYPE: link_type_q <= cfg_data_i[2:0];
        CFG_IPV6_CODE: ipv6_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the parser by one byte
  always_comb begin
    pos_d     = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;
    phase_d   = phase_q;
    proto_d   = proto_q;
    inner_d   = inner_q;
    labels_d  = labels_q;
    mbase_d   = mbase_q;
    vmpls_d   = vmpls_q;
    dec       = 1'b0;
    dec_st    = ST_OK;
    dec_off   = 6'd0;
    dec_hs    = 5'd0;
    shift16   = {proto_q[7:0], b};
    mpls_rel  = pos_q - {4'd0, mbase_q};
    mpls_off  = 7'd0;

    if (!done_q) begin
      case (phase_q)
        PH_HEADER: begin
          case (link_type_q)
            LT_NULL: begin
              if (pos_q < 8'd4) begin
                proto_d[8*pos_q[1:0] +: 8] = proto_q[8*pos_q[1:0] +: 8] | b;
              end
              if (pos_q == 8'd3) begin
                dec = 1'b1;
                dec_hs = HS_NULL;
                dec_st = (proto_d == FAM_INET || proto_d == {24'd0, ipv6_code_q} ||
                          proto_d == FAM_INET6A || proto_d == FAM_INET6B ||
                          proto_d == FAM_INET6C) ? ST_OK : ST_NONIP_NULL;
              end
            end
            LT_ETHERNET: begin
              if (pos_q == 8'd12 || pos_q == 8'd13) begin
                proto_d = {16'd0, shift16};
              end
              if (pos_q == 8'd13) begin
                if (shift16 == ETH_MPLS) begin
                  phase_d  = PH_MPLS;
                  mbase_d  = MPLS_BASE_ETH;
                  vmpls_d  = 1'b1;
                  labels_d = 4'd0;
                end else if (shift16 == ETH_VLAN) begin
                  phase_d = PH_VLAN;
                end else if (shift16 == ETH_PPPOE) begin
                  phase_d = PH_PPPOE;
                end else begin
                  dec    = 1'b1;
                  dec_hs = HS_ETHERNET;
                end
              end
            end
            LT_PPP: begin
              if (pos_q == 8'd2 || pos_q == 8'd3) begin
                proto_d = {16'd0, shift16};
              end
              if (pos_q == 8'd3) begin
                if (shift16 == PPP_MPLS) begin
                  phase_d  = PH_MPLS;
                  mbase_d  = MPLS_BASE_PPP;
                  vmpls_d  = 1'b1;
                  labels_d = 4'd0;
                end else begin
                  dec    = 1'b1;
                  dec_hs = HS_PPP;
                  dec_st = (shift16 == PPP_IPV4 || shift16 == PPP_IPV6) ?
                           ST_OK : ST_NONIP_PPP;
                end
              end
            end
            default: begin
              // Fixed-size headers: decide on the first byte
              proto_d = 32'd0;
              dec     = 1'b1;
              if (link_type_q == LT_FDDI) begin
                dec_hs = HS_FDDI;
              end else if (link_type_q == LT_COOKED) begin
                dec_hs = HS_COOKED;
              end
            end
          endcase
        end
        PH_VLAN: begin
          if (pos_q == 8'd20 || pos_q == 8'd21) begin
            inner_d = {inner_q[7:0], b};
          end
          if (pos_q == 8'd21) begin
            dec     = 1'b1;
            dec_off = (inner_d == ETH_IPV4) ? OFF_VLAN2 : OFF_VLAN;
          end
        end
        PH_PPPOE: begin
          if (pos_q == 8'd20) begin
            proto_d = {24'd0, b};
          end
          if (pos_q == 8'd21) begin
            proto_d = {16'd0, shift16};
            dec     = 1'b1;
            dec_off = OFF_PPPOE;
            dec_st  = (shift16 == PPP_IPV4 || shift16 == PPP_IPV6) ?
                      ST_OK : ST_NONIP_PPPOE;
          end
        end
        default: begin
          // Label stack: the third byte of each label holds the end bit
          if (pos_q >= {4'd0, mbase_q} && mpls_rel[1:0] == 2'd2) begin
            labels_d = labels_q + 4'd1;
            mpls_off = {3'd0, mbase_q} + {1'b0, labels_d, 2'b00};
            if (b[0]) begin
              dec     = 1'b1;
              dec_off = mpls_off[5:0];
            end else if (labels_d >= MaxLabelsW) begin
              dec    = 1'b1;
              dec_st = ST_DEEP_STACK;
            end
          end
        end
      endcase
    end

    // Latch the verdict; error verdicts carry no offset or size
    done_d    = done_q | dec;
    vstatus_d = dec ? dec_st : vstatus_q;
    voffset_d = dec ? ((dec_st == ST_OK) ? dec_off : 6'd0) : voffset_q;
    vheader_d = dec ? ((dec_st == ST_OK) ? dec_hs : 5'd0) : vheader_q;

    result.status         = done_d ? vstatus_d : ST_TRUNCATED;
    result.payload_offset = done_d ? voffset_d : 6'd0;
    result.header_size    = done_d ? vheader_d : 5'd0;
    result.protocol_code  = proto_d;
    result.had_mpls       = vmpls_d;
    result.label_count    = labels_d;
  end

  // Update parser state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 8'd0;
      phase_q   <= PH_HEADER;
      proto_q   <= 32'd0;
      inner_q   <= 16'd0;
      vstatus_q <= ST_OK;
      voffset_q <= 6'd0;
      vheader_q <= 5'd0;
      labels_q  <= 4'd0;
      done_q    <= 1'b0;
      mbase_q   <= 4'd0;
      vmpls_q   <= 1'b0;
    end else if (in_fire) begin
      if (in_data_i.last_byte) begin
        pos_q     <= 8'd0;
        phase_q   <= PH_HEADER;
        proto_q   <= 32'd0;
        inner_q   <= 16'd0;
        vstatus_q <= ST_OK;
        voffset_q <= 6'd0;
        vheader_q <= 5'd0;
        labels_q  <= 4'd0;
        done_q    <= 1'b0;
        mbase_q   <= 4'd0;
        vmpls_q   <= 1'b0;
      end else begin
        pos_q     <= pos_d;
        phase_q   <= phase_d;
        proto_q   <= proto_d;
        inner_q   <= inner_d;
        vstatus_q <= vstatus_d;
        voffset_q <= voffset_d;
        vheader_q <= vheader_d;
        labels_q  <= labels_d;
        done_q    <= done_d;
        mbase_q   <= mbase_d;
        vmpls_q   <= vmpls_d;
      end
    end
  end

  // Hold the verdict until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && in_data_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.last_byte) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A last byte never overwrites a verdict that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.last_byte |-> !out_valid_q || out_ready_i)
    else $error("verdict overwritten before it was taken");

  // The parser starts over after each packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.last_byte |=> pos_q == 8'd0 && !done_q && !vmpls_q)
    else $error("parser not cleared after last byte");

  // Error verdicts carry no offset and no header size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.status != ST_OK |->
      out_data_q.payload_offset == 6'd0 && out_data_q.header_size == 5'd0)
    else $error("error verdict with nonzero offset or size");

  // The label count never passes the stack limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    labels_q <= MaxLabelsW)
    else $error("label count beyond limit");

endmodule
